// ===== src/assert_macros.svh =====
// Assertion macros shared by the activation unit RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== src/nau_pkg.sv =====
// Package for the neural activation unit: function codes, Q30 constants
// and the elaboration-time divider used to build the curve ROM. No dependencies.
`timescale 1ns / 1ps

package nau_pkg;

  // Function select codes
  typedef enum logic [2:0] {
    FN_HARDLIM  = 3'd0,
    FN_SIGN     = 3'd1,
    FN_DEADZONE = 3'd2,
    FN_LINEAR   = 3'd3,
    FN_RELU     = 3'd4,
    FN_SIGMOID  = 3'd5,
    FN_TANH     = 3'd6,
    FN_OFF      = 3'd7
  } nau_func_t;

  localparam int FSEL_W = 3;
  localparam int Q30_FRAC = 30;
  // Curve entries are in [0, 1.0] in Q30
  localparam int CURVE_W = Q30_FRAC + 1;
  // Curve value after tanh scaling, signed Q30
  localparam int YW = Q30_FRAC + 2;
  localparam logic [63:0] Q30_ONE = 64'd1 << Q30_FRAC;

  // Restoring shift-subtract divide, used only while building constants
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== src/neural_activation_unit_core.sv =====
// Neural activation unit top level: six-stage pipeline with curve ROM.
// Depends on nau_pkg and assert_macros.svh.
//
//  channel | signals                      | payload
//  --------+------------------------------+-------------------------------------
//  input   | s_tvalid s_tready s_tdata    | sample
//  output  | m_tvalid m_tready m_tdata    | activation, slope
//  config  | cfg_valid cfg_ready cfg_data | function_select
//
// One sample per cycle sustained while the output is not stalled; each result
// passes through the six registered stages, including the ROM read stage and the two multiplier stages.
// Reset clears valid bits and sets function_select to linear.
// A stalled output register holds the whole pipeline; nothing is dropped.
// Configuration beats are always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module neural_activation_unit_core #(
  parameter int DATA_WIDTH        = 24,
  parameter int FRAC_BITS         = 16,
  parameter int CURVE_TABLE_DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // sample
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // activation, slope
  output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [nau_pkg::FSEL_W-1:0]              cfg_data
);

  localparam int OUT_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int VW    = DATA_WIDTH + 4;
  localparam int AW    = $clog2(CURVE_TABLE_DEPTH + 1);
  localparam int OFFW  = FRAC_BITS + 4;
  localparam int NUMW  = OFFW + AW;
  localparam int PW    = OFFW + 33;
  localparam int SH    = nau_pkg::Q30_FRAC - FRAC_BITS;

  localparam logic signed [VW-1:0] HI_V = VW'(64'd8 << FRAC_BITS);
  localparam logic signed [VW-1:0] LO_V = -HI_V;
  localparam logic signed [DATA_WIDTH-1:0] FIX_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic [33:0] FIX_ONE_W = 34'(64'd1 << FRAC_BITS);
  localparam logic [33:0] HALF_W = 34'(64'd1 << (SH - 1));
  localparam logic [33:0] Q30_W = 34'(nau_pkg::Q30_ONE);
  localparam logic signed [nau_pkg::YW-1:0] Q30_Y = nau_pkg::YW'(nau_pkg::Q30_ONE);
  localparam logic signed [PW-1:0] RND = PW'((64'd1 << OFFW) - 64'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CURVE_TABLE_DEPTH);

  typedef logic [nau_pkg::CURVE_W-1:0] curve_rom_t [0:CURVE_TABLE_DEPTH];

  // Logistic curve over [-8, 8] in Q30, built at elaboration
  function automatic curve_rom_t build_curve();
    curve_rom_t rom;
    logic signed [63:0] off;
    logic signed [63:0] acc;
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] s;
    for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
      off = 64'(16 * k) - 64'(8 * CURVE_TABLE_DEPTH);
      mag = (off < 0) ? 64'(-off) : 64'(off);
      u = (mag << 27) / CURVE_TABLE_DEPTH;
      acc = $signed(nau_pkg::Q30_ONE);
      term = nau_pkg::Q30_ONE;
      // Taylor sum of e^-u, where u is the magnitude divided by 8
      for (int i = 1; i <= 20; i++) begin
        term = nau_pkg::udiv((term * u) >> 30, 64'(i));
        if ((i % 2) == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) acc = '0;
      if (acc > $signed(nau_pkg::Q30_ONE)) acc = $signed(nau_pkg::Q30_ONE);
      // Raise to the eighth power
      for (int j = 0; j < 3; j++) begin
        acc = $signed((64'(acc) * 64'(acc) + (64'd1 << 29)) >> 30);
      end
      s = nau_pkg::udiv(64'd1 << 60, nau_pkg::Q30_ONE + 64'(acc));
      rom[k] = (off < 0) ? nau_pkg::CURVE_W'(nau_pkg::Q30_ONE - s)
                         : nau_pkg::CURVE_W'(s);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

  // Signed Q30 to output format, rounding half up
  function automatic logic [DATA_WIDTH-1:0] q30_to_out(input logic signed [33:0] q);
    logic [33:0] w;
    logic [33:0] r;
    w = 34'(q) + Q30_W + HALF_W;
    r = w >> SH;
    return DATA_WIDTH'(r - FIX_ONE_W);
  endfunction

  function automatic logic is_curve(input nau_pkg::nau_func_t f);
    return (f == nau_pkg::FN_SIGMOID) || (f == nau_pkg::FN_TANH);
  endfunction

  logic adv;
  nau_pkg::nau_func_t fsel;

  // Stage 1 registers
  logic                   v1;
  nau_pkg::nau_func_t     fn1;
  logic [NUMW-1:0]        num1;
  logic                   sat_lo1, sat_hi1;
  logic [DATA_WIDTH-1:0]  act1, slope1;

  // Stage 2 registers
  logic                        v2;
  nau_pkg::nau_func_t          fn2;
  logic [nau_pkg::CURVE_W-1:0] rom_lo2, rom_hi2;
  logic [OFFW-1:0]             rem2;
  logic [DATA_WIDTH-1:0]       act2, slope2;

  // Stage 3 registers
  logic                        v3;
  nau_pkg::nau_func_t          fn3;
  logic signed [PW-1:0]        p3;
  logic [nau_pkg::CURVE_W-1:0] base3;
  logic [DATA_WIDTH-1:0]       act3, slope3;

  // Stage 4 registers
  logic                           v4;
  nau_pkg::nau_func_t             fn4;
  logic signed [nau_pkg::YW-1:0]  y4;
  logic [DATA_WIDTH-1:0]          act4, slope4;

  // Stage 5 registers
  logic                           v5;
  nau_pkg::nau_func_t             fn5;
  logic signed [nau_pkg::YW-1:0]  y5;
  logic signed [63:0]             prod5;
  logic [DATA_WIDTH-1:0]          act5, slope5;

  // Combinational stage logic
  logic signed [DATA_WIDTH-1:0] x0;
  logic signed [VW-1:0]         v0;
  logic [OFFW-1:0]              off0;
  logic [DATA_WIDTH-1:0]        act0, slope0;
  logic [AW-1:0]                lo_addr, hi_addr;
  logic signed [nau_pkg::CURVE_W:0] diff2;
  logic signed [PW-1:0]         p_adj;
  logic signed [32:0]           q3;
  logic signed [32:0]           y1_3;
  logic signed [32:0]           yt_3;
  logic signed [nau_pkg::YW-1:0] mb4;
  logic [30:0]                  pr5;
  logic signed [33:0]           slope_q5;
  logic [DATA_WIDTH-1:0]        act_out, slope_out;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  // Hold the function select
  always_ff @(posedge clk) begin
    if (rst) begin
      fsel <= nau_pkg::FN_LINEAR;
    end else if (cfg_valid) begin
      fsel <= nau_pkg::nau_func_t'(cfg_data);
    end
  end

  // Stage 1: piecewise functions, curve argument and table position
  always_comb begin
    x0 = $signed(s_tdata[DATA_WIDTH-1:0]);
    v0 = (fsel == nau_pkg::FN_TANH) ? VW'(x0) <<< 1 : VW'(x0);
    off0 = OFFW'(v0 - LO_V);
    slope0 = FIX_ONE;
    case (fsel)
      nau_pkg::FN_HARDLIM:  act0 = (x0 >= 0) ? FIX_ONE : '0;
      nau_pkg::FN_SIGN:     act0 = (x0 > 0) ? FIX_ONE : ((x0 < 0) ? -FIX_ONE : '0);
      nau_pkg::FN_DEADZONE: act0 = (x0 >= FIX_ONE) ? FIX_ONE
                                   : ((x0 <= -FIX_ONE) ? -FIX_ONE : '0);
      nau_pkg::FN_LINEAR:   act0 = x0;
      nau_pkg::FN_RELU:     act0 = (x0 > 0) ? x0 : '0;
      nau_pkg::FN_SIGMOID:  act0 = '0;
      nau_pkg::FN_TANH:     act0 = '0;
      default: begin
        act0 = '0;
        slope0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn1     <= fsel;
      num1    <= NUMW'({{AW{1'b0}}, off0} * NUMW'(CURVE_TABLE_DEPTH));
      sat_lo1 <= (v0 <= LO_V);
      sat_hi1 <= (v0 >= HI_V);
      act1    <= act0;
      slope1  <= slope0;
    end
  end

  // Stage 2: read both neighbors from the curve ROM
  always_comb begin
    if (sat_hi1) begin
      lo_addr = LAST_ADDR;
      hi_addr = LAST_ADDR;
    end else if (sat_lo1) begin
      lo_addr = '0;
      hi_addr = AW'(1);
    end else begin
      lo_addr = num1[NUMW-1:OFFW];
      hi_addr = num1[NUMW-1:OFFW] + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn2     <= fn1;
      rom_lo2 <= CURVE_ROM[lo_addr];
      rom_hi2 <= CURVE_ROM[hi_addr];
      rem2    <= (sat_lo1 || sat_hi1) ? '0 : num1[OFFW-1:0];
      act2    <= act1;
      slope2  <= slope1;
    end
  end

  // Stage 3: scale the step between neighbors by the remainder
  assign diff2 = $signed({1'b0, rom_hi2}) - $signed({1'b0, rom_lo2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn3    <= fn2;
      p3     <= PW'(diff2) * $signed({1'b0, rem2});
      base3  <= rom_lo2;
      act3   <= act2;
      slope3 <= slope2;
    end
  end

  // Stage 4: truncate toward zero, add base, apply tanh scaling
  always_comb begin
    p_adj = (p3 < 0) ? p3 + RND : p3;
    q3    = p_adj[PW-1:OFFW];
    y1_3  = $signed({2'b00, base3}) + q3;
    yt_3  = (y1_3 <<< 1) - 33'(Q30_Y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn4    <= fn3;
      y4     <= (fn3 == nau_pkg::FN_TANH) ? nau_pkg::YW'(yt_3) : nau_pkg::YW'(y1_3);
      act4   <= act3;
      slope4 <= slope3;
    end
  end

  // Stage 5: derivative product
  assign mb4 = (fn4 == nau_pkg::FN_TANH) ? y4 : Q30_Y - y4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn5    <= fn4;
      y5     <= y4;
      prod5  <= 64'(y4) * 64'(mb4);
      act5   <= act4;
      slope5 <= slope4;
    end
  end

  // Stage 6: finish slope, convert to output format, pick the result
  always_comb begin
    pr5 = prod5[60:30];
    slope_q5 = (fn5 == nau_pkg::FN_TANH) ? $signed(Q30_W) - $signed({3'b000, pr5})
                                         : $signed({3'b000, pr5});
    if (is_curve(fn5)) begin
      act_out   = q30_to_out(34'(y5));
      slope_out = q30_to_out(slope_q5);
    end else begin
      act_out   = act5;
      slope_out = slope5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OUT_W'({slope_out, act_out});
    end
  end

  // Checks
  `ASSERT_NEXT(a_stage_move, clk, rst, adv && v1, v2, "stage 1 beat lost on advance")
  `ASSERT_IMPLY(a_sat_excl, clk, rst, v1, !(sat_lo1 && sat_hi1), "both saturation flags set")
  `ASSERT_IMPLY(a_curve_range, clk, rst, v5 && is_curve(fn5), (y5 <= Q30_Y) && (y5 >= -Q30_Y), "curve value out of range")
  `ASSERT_IMPLY(a_sig_prod, clk, rst, v5 && (fn5 == nau_pkg::FN_SIGMOID), !prod5[63], "negative sigmoid slope product")

endmodule
